### sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/dnsg_pkg.sv
package dnsg_pkg;

    // sizing
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLES_PER_MS   = 48;

    localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_BITS  = IDX_BITS - 2;
    localparam int QTR_DEPTH = 1 << QTR_BITS;
    localparam int Z_SHIFT   = 32 - IDX_BITS;

    localparam int NOTE_W   = 4;
    localparam int OCT_W    = 4;
    localparam int DUR_W    = 16;
    localparam int AMP_W    = 25;
    localparam int SAMPLE_W = 26;
    localparam int MAG_W    = 31;
    localparam int COUNT_W  = $clog2((1 << DUR_W) * SAMPLES_PER_MS);
    localparam int NOTES    = 12;

    localparam logic [AMP_W-1:0]  AMP_RESET = AMP_W'(26843545);
    localparam logic [NOTE_W-1:0] NOTE_MAX  = NOTE_W'(NOTES - 1);
    localparam logic [OCT_W-1:0]  OCT_REF   = OCT_W'(4);

    // polynomial coefficients for the sine quarter wave, q30
    localparam logic [63:0] COEF_A1 = 64'd1686629713;
    localparam logic [63:0] COEF_A3 = 64'd693598668;
    localparam logic [63:0] COEF_A5 = 64'd85569306;
    localparam logic [63:0] COEF_A7 = 64'd5026995;
    localparam logic [63:0] COEF_A9 = 64'd172272;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // octave-4 note frequencies in centihertz, c through b
    localparam int unsigned NOTE_CENTIHZ [NOTES] = '{
        26163, 27718, 29366, 31113, 32963, 34923,
        36999, 39200, 41530, 44000, 46616, 49388
    };
    localparam longint unsigned STEP_DIV = longint'(SAMPLES_PER_MS) * 100000;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [NOTE_W-1:0]   note;
        logic [OCT_W-1:0]    octave;
        logic [DUR_W-1:0]    duration_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } out_item_t;

    // phase stage to sine lookup
    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
        logic                last;
    } phase_stage_t;

    // sine lookup to scaler
    typedef struct packed {
        logic             valid;
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             last;
    } mag_stage_t;

    typedef logic [MAG_W-1:0]      mag_table_t  [QTR_DEPTH];
    typedef logic [PHASE_BITS-1:0] step_table_t [NOTES];

    // sine magnitude in q30 for quarter-wave position k
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] m;
        z  = 64'(k) << Z_SHIFT;
        z2 = (z * z) >> 30;
        p  = COEF_A9;
        p  = COEF_A7 - ((z2 * p) >> 30);
        p  = COEF_A5 - ((z2 * p) >> 30);
        p  = COEF_A3 - ((z2 * p) >> 30);
        p  = COEF_A1 - ((z2 * p) >> 30);
        m  = (z * p) >> 30;
        if (m > Q30_ONE) begin
            m = Q30_ONE;
        end
        return MAG_W'(m);
    endfunction

    function automatic mag_table_t build_mag_table();
        mag_table_t tbl;
        for (int i = 0; i < QTR_DEPTH; i++) begin
            tbl[i] = sine_mag(int'(i));
        end
        return tbl;
    endfunction

    // rounded octave-4 phase increments
    function automatic step_table_t build_step_table();
        step_table_t  tbl;
        logic [127:0] num;
        for (int i = 0; i < NOTES; i++) begin
            num    = (128'(NOTE_CENTIHZ[i]) << PHASE_BITS) + 128'(STEP_DIV / 2);
            tbl[i] = PHASE_BITS'(num / 128'(STEP_DIV));
        end
        return tbl;
    endfunction

    localparam mag_table_t  MAG_TABLE = build_mag_table();
    localparam logic [MAG_W-1:0] MAG_FULL = sine_mag(QTR_DEPTH);
    localparam step_table_t NOTE_STEP = build_step_table();

endpackage

### sv/dds_note_sine_generator.sv
// Note tone generator, direct digital synthesis with a sine lookup.
// Input channel s_valid/s_ready/s_item: OP_START loads a note (c..b),
// an octave (4 is the reference) and a length in milliseconds, clears
// the phase and arms duration_ms*48 samples; it never returns a result.
// OP_TICK advances the phase and returns one signed sample while samples
// remain, with last_sample set on the final one; an idle tick returns nothing.
// Output channel m_valid/m_ready/m_item carries sample and last_sample.
// cfg_wr_en/cfg_wr_data write the 25-bit amplitude, to be done while idle.
// A tick's sample passes through the phase, sine lookup and scaled output
// registers before m_valid rises.
// Throughput: one item per cycle while the receiver keeps m_ready high.
// When the receiver stalls the three stages fill and s_ready drops;
// everything flows again as soon as m_ready returns.
// Reset (aresetn low, synchronous) empties the pipeline, clears the
// phase, increment and sample count, and sets the amplitude to 26843545.
`include "assert_macros.svh"

module dds_note_sine_generator
    import dnsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [AMP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);

    logic [AMP_W-1:0] amplitude_reg;
    phase_stage_t     p_stage;
    logic             p_ready;
    mag_stage_t       m_stage;
    logic             m_stage_ready;

    // amplitude register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg <= AMP_RESET;
        end else if (cfg_wr_en) begin
            amplitude_reg <= cfg_wr_data;
        end
    end

    dnsg_phase u_phase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .p_stage (p_stage),
        .p_ready (p_ready)
    );

    dnsg_sine_lut u_sine_lut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .p_stage (p_stage),
        .p_ready (p_ready),
        .m_stage (m_stage),
        .m_ready (m_stage_ready)
    );

    dnsg_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .amplitude     (amplitude_reg),
        .m_stage       (m_stage),
        .m_stage_ready (m_stage_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item)
    );

    `ASSERT_ALWAYS(a_no_output_after_reset, aclk, !aresetn |=> !m_valid, "output valid after reset")

endmodule

### sv/dnsg_phase.sv
`include "assert_macros.svh"

module dnsg_phase
    import dnsg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_item,
    output phase_stage_t p_stage,
    input  logic         p_ready
);

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [COUNT_W-1:0]    samples_left_reg, samples_left_next;
    phase_stage_t          p_stage_reg, p_stage_next;

    logic                  fire;
    logic [NOTE_W-1:0]     note_sel;
    logic [PHASE_BITS-1:0] base_step;
    logic [PHASE_BITS-1:0] step_shifted;
    logic [PHASE_BITS-1:0] phase_sum;

    assign s_ready = !p_stage_reg.valid || p_ready;
    assign fire    = s_valid && s_ready;
    assign p_stage = p_stage_reg;

    // increment for the requested note and octave
    assign note_sel  = (s_item.note > NOTE_MAX) ? NOTE_MAX : s_item.note;
    assign base_step = NOTE_STEP[note_sel];
    assign step_shifted = (s_item.octave >= OCT_REF)
                        ? (base_step << (s_item.octave - OCT_REF))
                        : (base_step >> (OCT_REF - s_item.octave));

    assign phase_sum = phase_acc_reg + phase_step_reg;

    // start loads the note, tick advances the phase while active
    always_comb begin
        phase_acc_next    = phase_acc_reg;
        phase_step_next   = phase_step_reg;
        samples_left_next = samples_left_reg;
        p_stage_next       = p_stage_reg;
        if (s_ready) begin
            p_stage_next.valid = 1'b0;
        end
        if (fire) begin
            if (s_item.opcode == OP_START) begin
                phase_step_next   = step_shifted;
                phase_acc_next    = '0;
                samples_left_next = COUNT_W'(s_item.duration_ms) * COUNT_W'(SAMPLES_PER_MS);
            end else if (samples_left_reg != '0) begin
                phase_acc_next     = phase_sum;
                samples_left_next  = samples_left_reg - 1'b1;
                p_stage_next.valid = 1'b1;
                p_stage_next.idx   = phase_sum[PHASE_BITS-1 -: IDX_BITS];
                p_stage_next.last  = (samples_left_reg == COUNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            samples_left_reg <= '0;
            p_stage_reg      <= '0;
        end else begin
            phase_acc_reg    <= phase_acc_next;
            phase_step_reg   <= phase_step_next;
            samples_left_reg <= samples_left_next;
            p_stage_reg      <= p_stage_next;
        end
    end

    `ASSERT_CLK(a_start_clears_phase, aclk, aresetn, fire && s_item.opcode == OP_START |=> phase_acc_reg == '0, "phase not cleared on start")
    `ASSERT_CLK(a_tick_counts_down, aclk, aresetn, fire && s_item.opcode == OP_TICK && samples_left_reg != '0 |=> samples_left_reg == $past(samples_left_reg) - 1'b1, "sample count did not step down")
    `ASSERT_CLK(a_idle_tick_silent, aclk, aresetn, fire && s_item.opcode == OP_TICK && samples_left_reg == '0 |=> !p_stage_reg.valid, "idle tick produced a sample")

endmodule

### sv/dnsg_sine_lut.sv
module dnsg_sine_lut
    import dnsg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  phase_stage_t p_stage,
    output logic         p_ready,
    output mag_stage_t   m_stage,
    input  logic         m_ready
);

    mag_stage_t           m_stage_reg;
    logic [1:0]           quad;
    logic [QTR_BITS-1:0]  k;
    logic [QTR_BITS-1:0]  mirror_k;
    logic [MAG_W-1:0]     mag_lookup;

    assign p_ready = !m_stage_reg.valid || m_ready;
    assign m_stage = m_stage_reg;

    // quarter-wave lookup, mirrored in odd quadrants
    assign quad     = p_stage.idx[IDX_BITS-1 -: 2];
    assign k        = p_stage.idx[QTR_BITS-1:0];
    assign mirror_k = ~k + 1'b1;

    always_comb begin
        if (!quad[0]) begin
            mag_lookup = MAG_TABLE[k];
        end else if (k == '0) begin
            mag_lookup = MAG_FULL;
        end else begin
            mag_lookup = MAG_TABLE[mirror_k];
        end
    end

    // stage register, advances when the next stage can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_stage_reg <= '0;
        end else if (p_ready) begin
            m_stage_reg.valid <= p_stage.valid;
            m_stage_reg.mag   <= mag_lookup;
            m_stage_reg.neg   <= quad[1];
            m_stage_reg.last  <= p_stage.last;
        end
    end

endmodule

### sv/dnsg_scale.sv
`include "assert_macros.svh"

module dnsg_scale
    import dnsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [AMP_W-1:0] amplitude,
    input  mag_stage_t       m_stage,
    output logic             m_stage_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);

    localparam int PROD_W = AMP_W + MAG_W;

    logic                       m_valid_reg;
    out_item_t                  m_item_reg;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          prod_rounded;
    logic [SAMPLE_W-1:0]        mag_scaled;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       load;

    assign m_stage_ready = !m_valid_reg || m_ready;
    assign load          = m_stage_ready && m_stage.valid;
    assign m_valid       = m_valid_reg;
    assign m_item        = m_item_reg;

    // amplitude times q30 magnitude, rounded, then signed
    assign prod         = PROD_W'(amplitude) * PROD_W'(m_stage.mag);
    assign prod_rounded = prod + (PROD_W'(1) << 29);
    assign mag_scaled   = prod_rounded[30 +: SAMPLE_W];
    assign sample_next  = m_stage.neg ? -$signed(mag_scaled) : $signed(mag_scaled);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_stage_ready) begin
            m_valid_reg <= m_stage.valid;
        end
    end

    // output register holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (m_stage_ready) begin
            m_item_reg.sample      <= sample_next;
            m_item_reg.last_sample <= m_stage.last;
        end
    end

    `ASSERT_CLK(a_sample_within_amplitude, aclk, aresetn, load |-> mag_scaled <= SAMPLE_W'(amplitude), "scaled sample exceeds amplitude")

endmodule
